FILE: rtl/spearman_rank_correlation_core_defines.svh
// Assertion helpers for the Spearman core. Both expect clk_i and rst_ni in scope.
`ifndef SPEARMAN_RANK_CORRELATION_CORE_DEFINES_SVH
`define SPEARMAN_RANK_CORRELATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SPEAR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define SPEAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spear_pkg.sv
`default_nettype none
package spear_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_BINS_DEF  = 4096;
  localparam int unsigned MAX_COUNT_DEF = 1023;

  // Fixed field widths of the bin and result beats
  localparam int unsigned AB_W   = 10;
  localparam int unsigned RHO_W  = 16;
  localparam int unsigned BINS_W = 13;

  // Q2.14 scaling of rho
  localparam int unsigned FRAC_W = 14;
  localparam int          ONE_Q  = 1 << FRAC_W;

  // Depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

endpackage
`default_nettype wire

FILE: rtl/spear_ifs.sv
`default_nettype none
// Bin channel: one pair of abundances per beat
interface spear_in_if;
  logic                        valid;
  logic                        ready;
  logic [spear_pkg::AB_W-1:0]  abundance_a;
  logic [spear_pkg::AB_W-1:0]  abundance_b;
  logic                        last_bin;

  modport source (output valid, abundance_a, abundance_b, last_bin, input ready);
  modport sink   (input valid, abundance_a, abundance_b, last_bin, output ready);
endinterface

// Result channel: one coefficient per data set
interface spear_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [spear_pkg::RHO_W-1:0] rho_fixed;
  logic                               degenerate;
  logic [spear_pkg::BINS_W-1:0]       bins_seen;

  modport source (output valid, rho_fixed, degenerate, bins_seen, input ready);
  modport sink   (input valid, rho_fixed, degenerate, bins_seen, output ready);
endinterface
`default_nettype wire

FILE: rtl/spear_fifo.sv
`default_nettype none
module spear_fifo #(
  parameter int unsigned W     = 2,
  parameter int unsigned DEPTH = spear_pkg::FIFO_DEPTH,
  localparam int unsigned PW   = $clog2(DEPTH),
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o,
  input  logic         pop_i
);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] fill_q;

  assign full_o  = (fill_q == NW'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spear_front.sv
`default_nettype none
module spear_front #(
  parameter int unsigned MAX_BINS  = spear_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_COUNT = spear_pkg::MAX_COUNT_DEF,
  localparam int unsigned IW       = $clog2(MAX_COUNT + 1),
  localparam int unsigned BEAT_W   = 2 * IW + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  spear_in_if.sink          bin_i,
  input  logic              hold_i,
  input  logic              full_i,
  output logic              push_o,
  output logic [BEAT_W-1:0] beat_o
);

  localparam int unsigned CW = $clog2(MAX_BINS + 1);

  logic [CW-1:0] fc_q, fc_d;
  logic          acc, keep;
  logic [IW-1:0] a_c, b_c;

  assign bin_i.ready = !full_i && !hold_i;
  assign acc         = bin_i.valid && bin_i.ready;
  assign keep        = (32'(fc_q) < MAX_BINS);

  // Saturate abundances to the histogram range
  assign a_c = (32'(bin_i.abundance_a) > MAX_COUNT) ? IW'(MAX_COUNT) : IW'(bin_i.abundance_a);
  assign b_c = (32'(bin_i.abundance_b) > MAX_COUNT) ? IW'(MAX_COUNT) : IW'(bin_i.abundance_b);

  // Queue kept bins and every end mark; drop overflow bins
  assign push_o = acc && (keep || bin_i.last_bin);
  assign beat_o = {a_c, b_c, keep, bin_i.last_bin};

  // Count bins of the current data set
  always_comb begin
    fc_d = fc_q;
    if (acc) begin
      if (bin_i.last_bin) begin
        fc_d = '0;
      end else if (keep) begin
        fc_d = fc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
    end else begin
      fc_q <= fc_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spear_div.sv
`default_nettype none
module spear_div #(
  parameter int unsigned NW = 2,
  parameter int unsigned DW = 2,
  localparam int unsigned KW = $clog2(NW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  logic          busy_q;
  logic [KW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q, rem_nx;
  logic [DW:0]   rem_sh;
  logic          ge;

  // One restoring step: shift in a numerator bit, subtract when it fits
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == KW'(NW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spear_back.sv
`default_nettype none
module spear_back #(
  parameter int unsigned MAX_BINS  = spear_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_COUNT = spear_pkg::MAX_COUNT_DEF,
  localparam int unsigned IW       = $clog2(MAX_COUNT + 1),
  localparam int unsigned BEAT_W   = 2 * IW + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fifo_valid_i,
  input  logic [BEAT_W-1:0] fifo_data_i,
  output logic              fifo_pop_o,
  output logic              init_busy_o,
  spear_out_if.source       result_o
);

  import spear_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_BINS + 1);
  localparam int unsigned PAW  = $clog2(MAX_BINS);
  localparam int unsigned HD   = MAX_COUNT + 1;
  localparam int unsigned RW   = $clog2(2 * MAX_BINS + 2);
  localparam int unsigned SW   = 2 * RW + CW;
  localparam int unsigned TW   = SW + 2;
  localparam int unsigned N2W  = 2 * CW;
  localparam int unsigned N3W  = 3 * CW;
  localparam int unsigned FDW  = N3W + 2;
  localparam int unsigned CMPW = (TW > FDW) ? TW : FDW;
  localparam int unsigned NW   = CMPW + FRAC_W;
  localparam int unsigned DW   = N3W + 1;
  localparam int          RHO_MIN = -ONE_Q;

  typedef enum logic [9:0] {
    ST_LOAD    = 10'b0000000001,
    ST_DRAIN   = 10'b0000000010,
    ST_RANK    = 10'b0000000100,
    ST_RANKEND = 10'b0000001000,
    ST_SUM     = 10'b0000010000,
    ST_SUMEND  = 10'b0000100000,
    ST_SCALE   = 10'b0001000000,
    ST_DIVGO   = 10'b0010000000,
    ST_DIV     = 10'b0100000000,
    ST_FIN     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   init_q;

  // Queue head
  logic [IW-1:0] head_a, head_b;
  logic          head_keep, head_last, pop;

  assign head_last = fifo_data_i[0];
  assign head_keep = fifo_data_i[1];
  assign head_b    = fifo_data_i[IW+1:2];
  assign head_a    = fifo_data_i[2*IW+1:IW+2];

  assign pop         = fifo_valid_i && (state_q == ST_LOAD);
  assign fifo_pop_o  = pop;
  assign init_busy_o = init_q;

  // Set size and power sums for the denominator
  logic [CW-1:0]  cnt_q;
  logic [N2W-1:0] n2_q, n2_d;
  logic [N3W-1:0] n3_q, n3_d, n2x, nx;
  logic           deg;

  assign deg = (cnt_q < CW'(2));
  assign n2x = N3W'(n2_q);
  assign nx  = N3W'(cnt_q);
  assign n3_d = n3_q + n2x + (n2x << 1) + nx + (nx << 1) + N3W'(1);
  assign n2_d = n2_q + N2W'({cnt_q, 1'b0}) + N2W'(1);

  // Memories
  logic [CW-1:0]     hist_a [HD];
  logic [CW-1:0]     hist_b [HD];
  logic [RW-1:0]     rank_a [HD];
  logic [RW-1:0]     rank_b [HD];
  logic [2*IW-1:0]   pstore [MAX_BINS];

  // Histogram read-modify-write pipeline
  logic          s1_vld_q, wr_vld_q;
  logic [IW-1:0] s1_a_q, s1_b_q, wr_a_q, wr_b_q;
  logic [CW-1:0] wr_da_q, wr_db_q, ha_rd_q, hb_rd_q, inc_a, inc_b;
  logic [IW-1:0] h_ra_a, h_ra_b, h_wa_a, h_wa_b;
  logic [CW-1:0] h_wd_a, h_wd_b;
  logic          h_we;

  // Rank walk
  logic [IW-1:0] v_q, wk_v_q;
  logic          wk_vld_q;
  logic [CW-1:0] ra_acc_q, rb_acc_q;
  logic [RW-1:0] rka_wd, rkb_wd;

  // Sum pipeline
  logic [CW-1:0]   i_q;
  logic [3:0]      sv_q;
  logic [2*IW-1:0] p_q;
  logic [RW-1:0]   rka_q, rkb_q, diff_q;
  logic [2*RW-1:0] sq_q;
  logic [SW-1:0]   sum_q;

  // Scaling and division
  logic [N3W-1:0]  d_c, d_q;
  logic [CMPW-1:0] t3, four_d, t_c, t_q;
  logic            div_start, div_busy;
  logic [NW-1:0]   div_quot;
  logic [DW-1:0]   div_rem;
  logic            rem_gt;
  logic [RHO_W:0]  c_w;
  logic signed [RHO_W+1:0] rho_w;
  logic [RHO_W-1:0] rho_cl;

  // Result register
  logic                    out_vld_q, slot_free;
  logic signed [RHO_W-1:0] out_rho_q;
  logic                    out_deg_q;
  logic [BINS_W-1:0]       out_bins_q;

  assign slot_free = !out_vld_q || result_o.ready;

  // Forward the last write when the same value repeats
  assign inc_a = ((wr_vld_q && (wr_a_q == s1_a_q)) ? wr_da_q : ha_rd_q) + 1'b1;
  assign inc_b = ((wr_vld_q && (wr_b_q == s1_b_q)) ? wr_db_q : hb_rd_q) + 1'b1;

  // Walk reads and clears; loading reads ahead and writes the count back
  assign h_ra_a = (state_q == ST_RANK) ? v_q : head_a;
  assign h_ra_b = (state_q == ST_RANK) ? v_q : head_b;
  assign h_we   = (state_q == ST_RANK) || s1_vld_q;
  assign h_wa_a = (state_q == ST_RANK) ? v_q : s1_a_q;
  assign h_wa_b = (state_q == ST_RANK) ? v_q : s1_b_q;
  assign h_wd_a = (state_q == ST_RANK) ? '0 : inc_a;
  assign h_wd_b = (state_q == ST_RANK) ? '0 : inc_b;

  // Double-scale tie-averaged rank: 2r + 1 + c
  assign rka_wd = {ra_acc_q, 1'b1} + RW'(ha_rd_q);
  assign rkb_wd = {rb_acc_q, 1'b1} + RW'(hb_rd_q);

  // Scale the sum: 3*S clamped to 4*D
  assign d_c    = n3_q - nx;
  assign t3     = CMPW'(sum_q) + (CMPW'(sum_q) << 1);
  assign four_d = CMPW'(d_c) << 2;
  assign t_c    = (t3 > four_d) ? four_d : t3;

  assign div_start = (state_q == ST_DIVGO);

  spear_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({t_q, FRAC_W'(0)}),
    .den_i   ({d_q, 1'b0}),
    .busy_o  (div_busy),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // Round to nearest and clamp
  assign rem_gt = (div_rem > {1'b0, d_q});
  assign c_w    = (RHO_W + 1)'(div_quot[RHO_W-1:0]) + (RHO_W + 1)'(rem_gt);
  assign rho_w  = $signed((RHO_W + 2)'(ONE_Q)) - $signed({1'b0, c_w});
  assign rho_cl = RHO_W'((rho_w < (RHO_W + 2)'(RHO_MIN)) ? (RHO_W + 2)'(RHO_MIN) : rho_w);

  // Sequence the phases
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (pop && head_last) state_d = ST_DRAIN;
      end
      ST_DRAIN:   state_d = ST_RANK;
      ST_RANK: begin
        if (v_q == '0) state_d = ST_RANKEND;
      end
      ST_RANKEND: begin
        if (init_q) begin
          state_d = ST_LOAD;
        end else if (deg) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (i_q == cnt_q - 1'b1) state_d = ST_SUMEND;
      end
      ST_SUMEND: begin
        if (sv_q == '0) state_d = ST_SCALE;
      end
      ST_SCALE:   state_d = ST_DIVGO;
      ST_DIVGO:   state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) state_d = ST_LOAD;
      end
      default:    state_d = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RANK;
      init_q    <= 1'b1;
      cnt_q     <= '0;
      n2_q      <= '0;
      n3_q      <= '0;
      s1_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      v_q       <= IW'(MAX_COUNT);
      wk_vld_q  <= 1'b0;
      ra_acc_q  <= '0;
      rb_acc_q  <= '0;
      i_q       <= '0;
      sv_q      <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= pop && head_keep;
      wr_vld_q <= s1_vld_q;

      if (pop && head_keep) begin
        cnt_q <= cnt_q + 1'b1;
        n2_q  <= n2_d;
        n3_q  <= n3_d;
      end

      // Walk from the largest abundance down
      if (state_q == ST_RANK) begin
        v_q <= v_q - 1'b1;
      end else begin
        v_q <= IW'(MAX_COUNT);
      end
      wk_vld_q <= (state_q == ST_RANK);
      if (wk_vld_q) begin
        ra_acc_q <= ra_acc_q + ha_rd_q;
        rb_acc_q <= rb_acc_q + hb_rd_q;
      end
      if ((state_q == ST_RANKEND) && init_q) begin
        init_q   <= 1'b0;
        ra_acc_q <= '0;
        rb_acc_q <= '0;
      end

      if (state_q == ST_RANKEND) begin
        i_q <= '0;
      end else if (state_q == ST_SUM) begin
        i_q <= i_q + 1'b1;
      end
      sv_q <= {sv_q[2:0], state_q == ST_SUM};
      if (sv_q[3]) begin
        sum_q <= sum_q + SW'(sq_q);
      end

      // Hand over the result and clear for the next data set
      if ((state_q == ST_FIN) && slot_free) begin
        out_vld_q <= 1'b1;
        cnt_q     <= '0;
        n2_q      <= '0;
        n3_q      <= '0;
        sum_q     <= '0;
        ra_acc_q  <= '0;
        rb_acc_q  <= '0;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    s1_a_q  <= head_a;
    s1_b_q  <= head_b;
    wr_a_q  <= s1_a_q;
    wr_b_q  <= s1_b_q;
    wr_da_q <= inc_a;
    wr_db_q <= inc_b;
    wk_v_q  <= v_q;
    diff_q  <= (rka_q >= rkb_q) ? rka_q - rkb_q : rkb_q - rka_q;
    sq_q    <= (2 * RW)'(diff_q) * (2 * RW)'(diff_q);
    if (state_q == ST_SCALE) begin
      t_q <= t_c;
      d_q <= d_c;
    end
    if ((state_q == ST_FIN) && slot_free) begin
      out_rho_q  <= deg ? '0 : $signed(rho_cl);
      out_deg_q  <= deg;
      out_bins_q <= BINS_W'(cnt_q);
    end
  end

  // Histograms
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hist_a[h_wa_a] <= h_wd_a;
      hist_b[h_wa_b] <= h_wd_b;
    end
    ha_rd_q <= hist_a[h_ra_a];
    hb_rd_q <= hist_b[h_ra_b];
  end

  // Pair store
  always_ff @(posedge clk_i) begin
    if (pop && head_keep) begin
      pstore[cnt_q[PAW-1:0]] <= {head_a, head_b};
    end
    p_q <= pstore[i_q[PAW-1:0]];
  end

  // Rank tables
  always_ff @(posedge clk_i) begin
    if (wk_vld_q) begin
      rank_a[wk_v_q] <= rka_wd;
      rank_b[wk_v_q] <= rkb_wd;
    end
    rka_q <= rank_a[p_q[2*IW-1:IW]];
    rkb_q <= rank_b[p_q[IW-1:0]];
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.rho_fixed  = out_rho_q;
  assign result_o.degenerate = out_deg_q;
  assign result_o.bins_seen  = out_bins_q;

endmodule
`default_nettype wire

FILE: rtl/spearman_rank_correlation_core.sv
`default_nettype none
// Spearman rank correlation with tie-averaged ranks. Bins stream in at one beat per cycle
// while the queue has room and no clearing pass runs; a four-entry queue parts the intake
// from the engine, so bins of the next data set keep flowing while the engine finishes.
// After the bin marked last the engine walks the abundance histograms from MAX_COUNT down
// to zero, clearing them on the way, sums squared rank differences over the n stored bins,
// one bin a cycle through the pair store and rank tables, then runs a one-bit-a-cycle
// divider and rounds rho to Q2.14. Sets of fewer than two bins skip the sum and divide and
// return zero with the degenerate flag. After reset a clearing pass runs before the first
// bin is taken.
module spearman_rank_correlation_core #(
  parameter int unsigned MAX_BINS  = spear_pkg::MAX_BINS_DEF,
  parameter int unsigned MAX_COUNT = spear_pkg::MAX_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spear_in_if.sink    bin_i,
  spear_out_if.source result_o
);

  import spear_pkg::*;

  `include "spearman_rank_correlation_core_defines.svh"

  localparam int unsigned IW     = $clog2(MAX_COUNT + 1);
  localparam int unsigned BEAT_W = 2 * IW + 2;

  logic              push, full, fifo_valid, pop, init_busy;
  logic [BEAT_W-1:0] beat, fifo_data;

  spear_front #(
    .MAX_BINS  (MAX_BINS),
    .MAX_COUNT (MAX_COUNT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_i),
    .hold_i (init_busy),
    .full_i (full),
    .push_o (push),
    .beat_o (beat)
  );

  spear_fifo #(
    .W     (BEAT_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (beat),
    .full_o  (full),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .pop_i   (pop)
  );

  spear_back #(
    .MAX_BINS  (MAX_BINS),
    .MAX_COUNT (MAX_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .fifo_pop_o   (pop),
    .init_busy_o  (init_busy),
    .result_o     (result_o)
  );

  // Checks
  `SPEAR_ASSERT(a_deg_zero, result_o.valid && result_o.degenerate,
                result_o.rho_fixed == '0, "degenerate result with nonzero rho")
  `SPEAR_ASSERT(a_rho_range, result_o.valid,
                ($signed(result_o.rho_fixed) >= -16'sd16384) &&
                ($signed(result_o.rho_fixed) <= 16'sd16384), "rho out of range")
  `SPEAR_ASSERT(a_no_take_init, bin_i.ready, !init_busy, "bin taken during clearing pass")
  `SPEAR_ASSERT_NEXT(a_init_once, !init_busy, !init_busy, "clearing pass restarted")

endmodule
`default_nettype wire
